@@ rtl/core/blrs_pkg.sv @@
// Shared constants, types and the brightness table of the backlight ramp sequencer.
package blrs_pkg;

	// Table geometry: 44 defined steps, padded with full scale up to 64
	localparam int TABLE_ENTRIES_DEF = 44;
	localparam int TBL_DEPTH         = 64;
	localparam int TBL_IDX_W         = 6;

	// Register reset values
	localparam logic [7:0]  RAMP_LIMIT_RST    = 8'd30;
	localparam logic [15:0] STEP_INTERVAL_RST = 16'd75;
	localparam logic [15:0] START_DELAY_RST   = 16'd100;
	localparam logic [23:0] LUX_THRESHOLD_RST = 24'd512;   // 2.0 lux in Q16.8

	// Register indexes
	localparam logic [1:0] CFG_RAMP_LIMIT    = 2'd0;
	localparam logic [1:0] CFG_STEP_INTERVAL = 2'd1;
	localparam logic [1:0] CFG_START_DELAY   = 2'd2;
	localparam logic [1:0] CFG_LUX_THRESHOLD = 2'd3;

	// Event kinds
	localparam logic [1:0] KIND_START = 2'd0;
	localparam logic [1:0] KIND_STOP  = 2'd1;
	localparam logic [1:0] KIND_LIGHT = 2'd2;
	localparam logic [1:0] KIND_TICK  = 2'd3;

	// Phase codes as reported on the result channel
	localparam logic [2:0] PHASE_INIT       = 3'd0;
	localparam logic [2:0] PHASE_WAIT_BOTH  = 3'd1;
	localparam logic [2:0] PHASE_WAIT_LIGHT = 3'd2;
	localparam logic [2:0] PHASE_WAIT_DELAY = 3'd3;
	localparam logic [2:0] PHASE_RAMP       = 3'd4;
	localparam logic [2:0] PHASE_END        = 3'd5;

	// Sequencer state, one-hot
	typedef enum logic [5:0] {
		PH_INIT       = 6'b000001,
		PH_WAIT_BOTH  = 6'b000010,
		PH_WAIT_LIGHT = 6'b000100,
		PH_WAIT_DELAY = 6'b001000,
		PH_RAMP       = 6'b010000,
		PH_END        = 6'b100000
	} phase_t;

	typedef struct packed {
		logic [7:0]  ramp_limit;
		logic [15:0] step_interval_ms;
		logic [15:0] start_delay_ms;
		logic [23:0] lux_threshold;
	} cfg_t;

	typedef struct packed {
		phase_t      phase;
		logic [15:0] timer_left;
		logic        timer_armed;
		logic [23:0] stored_lux;
	} seq_state_t;

	typedef struct packed {
		logic [2:0] phase;
		logic       set_brightness;
		logic [7:0] brightness;
		logic       restore_request;
	} result_t;

	// Brightness steps, nondecreasing
	localparam logic [7:0] RAMP_TABLE [TBL_DEPTH] = '{
		8'd4,   8'd4,   8'd5,   8'd5,   8'd6,   8'd6,   8'd7,   8'd8,
		8'd9,   8'd9,   8'd10,  8'd11,  8'd13,  8'd14,  8'd15,  8'd17,
		8'd18,  8'd20,  8'd22,  8'd24,  8'd27,  8'd30,  8'd33,  8'd36,
		8'd39,  8'd43,  8'd48,  8'd52,  8'd58,  8'd63,  8'd70,  8'd77,
		8'd84,  8'd93,  8'd102, 8'd112, 8'd124, 8'd136, 8'd150, 8'd166,
		8'd181, 8'd199, 8'd219, 8'd241, 8'd255, 8'd255, 8'd255, 8'd255,
		8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
		8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255
	};

	function automatic logic [2:0] phase_code(input phase_t ph);
		logic [2:0] code;
		case (ph)
			PH_INIT:       code = PHASE_INIT;
			PH_WAIT_BOTH:  code = PHASE_WAIT_BOTH;
			PH_WAIT_LIGHT: code = PHASE_WAIT_LIGHT;
			PH_WAIT_DELAY: code = PHASE_WAIT_DELAY;
			PH_RAMP:       code = PHASE_RAMP;
			PH_END:        code = PHASE_END;
			default:       code = PHASE_INIT;
		endcase
		return code;
	endfunction

endpackage

@@ rtl/core/blrs_if.sv @@
// Valid/ready channels for sequencer events and results.
interface blrs_event_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [23:0] lux;
	logic [7:0]  display_brightness;

	modport source (output valid, kind, lux, display_brightness, input ready);
	modport sink   (input valid, kind, lux, display_brightness, output ready);
endinterface

interface blrs_result_if;
	logic       valid;
	logic       ready;
	logic [2:0] phase;
	logic       set_brightness;
	logic [7:0] brightness;
	logic       restore_request;

	modport source (output valid, phase, set_brightness, brightness, restore_request,
		input ready);
	modport sink   (input valid, phase, set_brightness, brightness, restore_request,
		output ready);
endinterface

@@ rtl/core/blrs_step.sv @@
// Next-state and result logic for one sequencer event.
module blrs_step #(
	parameter int TABLE_ENTRIES = blrs_pkg::TABLE_ENTRIES_DEF,
	parameter int IDX_W         = $clog2(TABLE_ENTRIES + 1)
) (
	input  blrs_pkg::cfg_t       cfg,
	input  blrs_pkg::seq_state_t st,
	input  logic [IDX_W-1:0]     ramp_index,
	input  logic [1:0]           kind,
	input  logic [23:0]          lux,
	input  logic [7:0]           display_brightness,
	output blrs_pkg::seq_state_t st_nxt,
	output logic [IDX_W-1:0]     ramp_index_nxt,
	output blrs_pkg::result_t    res
);

	localparam int IDX_X_W = blrs_pkg::TBL_IDX_W + 1;
	localparam logic [IDX_W-1:0] TBL_LEN = IDX_W'(TABLE_ENTRIES);

	logic [IDX_W-1:0]   search_idx;
	logic [IDX_W-1:0]   step_idx;
	logic [IDX_X_W-1:0] step_idx_x;
	logic [7:0]         step_val;
	logic [23:0]        lux_eff;
	logic               enter_ramp;
	logic               ramp_expiry;
	logic               step_go;

	// First table entry above the present brightness; table length if none
	always_comb begin
		search_idx = TBL_LEN;
		for (int j = TABLE_ENTRIES - 1; j >= 0; j--) begin
			if (blrs_pkg::RAMP_TABLE[j] > display_brightness) begin
				search_idx = IDX_W'(j);
			end
		end
	end

	// Event decode, timer and phase transitions
	always_comb begin
		st_nxt         = st;
		ramp_index_nxt = ramp_index;
		lux_eff        = st.stored_lux;
		enter_ramp     = 1'b0;
		ramp_expiry    = 1'b0;
		res.set_brightness  = 1'b0;
		res.brightness      = 8'd0;
		res.restore_request = 1'b0;

		case (kind)
			blrs_pkg::KIND_START: begin
				if (st.phase == blrs_pkg::PH_INIT) begin
					st_nxt.phase       = blrs_pkg::PH_WAIT_BOTH;
					st_nxt.timer_left  = cfg.start_delay_ms;
					st_nxt.timer_armed = 1'b1;
				end
			end
			blrs_pkg::KIND_STOP: begin
				if (st.phase == blrs_pkg::PH_WAIT_BOTH || st.phase == blrs_pkg::PH_WAIT_LIGHT ||
				    st.phase == blrs_pkg::PH_WAIT_DELAY || st.phase == blrs_pkg::PH_RAMP) begin
					st_nxt.phase        = blrs_pkg::PH_END;
					st_nxt.timer_left   = 16'd0;
					st_nxt.timer_armed  = 1'b0;
					res.restore_request = 1'b1;
				end
			end
			blrs_pkg::KIND_LIGHT: begin
				// Sample is always kept, only the wait-both and wait-light phases react
				st_nxt.stored_lux = lux;
				lux_eff           = lux;
				if (st.phase == blrs_pkg::PH_WAIT_BOTH) begin
					st_nxt.phase = blrs_pkg::PH_WAIT_DELAY;
				end else if (st.phase == blrs_pkg::PH_WAIT_LIGHT) begin
					enter_ramp = 1'b1;
				end
			end
			blrs_pkg::KIND_TICK: begin
				if (st.timer_armed) begin
					if (st.timer_left > 16'd1) begin
						st_nxt.timer_left = st.timer_left - 16'd1;
					end else begin
						// Expiry
						st_nxt.timer_left  = 16'd0;
						st_nxt.timer_armed = 1'b0;
						if (st.phase == blrs_pkg::PH_WAIT_BOTH) begin
							st_nxt.phase = blrs_pkg::PH_WAIT_LIGHT;
						end else if (st.phase == blrs_pkg::PH_WAIT_DELAY) begin
							enter_ramp = 1'b1;
						end else if (st.phase == blrs_pkg::PH_RAMP) begin
							ramp_expiry = 1'b1;
						end
					end
				end
			end
			default: ;
		endcase

		// Ramp entry: bright ambient ends the run, else start from the search
		step_go = 1'b0;
		if (enter_ramp) begin
			if (lux_eff >= cfg.lux_threshold) begin
				st_nxt.phase        = blrs_pkg::PH_END;
				st_nxt.timer_left   = 16'd0;
				st_nxt.timer_armed  = 1'b0;
				res.restore_request = 1'b1;
			end else begin
				st_nxt.phase   = blrs_pkg::PH_RAMP;
				ramp_index_nxt = search_idx;
				step_go        = (search_idx < TBL_LEN);
			end
		end
		if (ramp_expiry) begin
			step_go = (ramp_index < TBL_LEN);
		end

		// One ramp step: issue the entry if within limit, always advance
		step_idx   = enter_ramp ? search_idx : ramp_index;
		step_idx_x = IDX_X_W'(step_idx);
		step_val   = blrs_pkg::RAMP_TABLE[step_idx_x[blrs_pkg::TBL_IDX_W-1:0]];
		if (step_go) begin
			if (step_val <= cfg.ramp_limit) begin
				res.set_brightness = 1'b1;
				res.brightness     = step_val;
				st_nxt.timer_left  = cfg.step_interval_ms;
				st_nxt.timer_armed = 1'b1;
			end
			ramp_index_nxt = IDX_W'(step_idx + 1'b1);
		end

		res.phase = blrs_pkg::phase_code(st_nxt.phase);
	end

endmodule

@@ rtl/core/backlight_ramp_sequencer.sv @@
// Backlight ramp sequencer: event register, one step stage, result register.
// An accepted event is held in the event register; when the step fires, its result is registered and offered.
// Throughput: one event per cycle; the whole event is handled in the single step stage.
// Backpressure on the result channel stalls the step stage and then event intake.
// Reset (arst_n low, asynchronous): phase init, timer disarmed, ramp index and stored lux
// zero, registers at their defaults, both channels empty.
module backlight_ramp_sequencer #(
	parameter int TABLE_ENTRIES = blrs_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [23:0]          cfg_wdata,
	blrs_event_if.sink           evt,
	blrs_result_if.source        res
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES + 1);

	blrs_pkg::cfg_t       cfg_q;
	blrs_pkg::seq_state_t st_q;
	blrs_pkg::seq_state_t st_nxt;
	blrs_pkg::result_t    res_nxt;
	blrs_pkg::result_t    res_q;
	logic [IDX_W-1:0]     ramp_index_q;
	logic [IDX_W-1:0]     ramp_index_nxt;

	logic        in_valid_s1;
	logic [1:0]  kind_s1;
	logic [23:0] lux_s1;
	logic [7:0]  disp_s1;
	logic        out_valid_q;
	logic        advance;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ramp_limit       <= blrs_pkg::RAMP_LIMIT_RST;
			cfg_q.step_interval_ms <= blrs_pkg::STEP_INTERVAL_RST;
			cfg_q.start_delay_ms   <= blrs_pkg::START_DELAY_RST;
			cfg_q.lux_threshold    <= blrs_pkg::LUX_THRESHOLD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				blrs_pkg::CFG_RAMP_LIMIT:    cfg_q.ramp_limit       <= cfg_wdata[7:0];
				blrs_pkg::CFG_STEP_INTERVAL: cfg_q.step_interval_ms <= cfg_wdata[15:0];
				blrs_pkg::CFG_START_DELAY:   cfg_q.start_delay_ms   <= cfg_wdata[15:0];
				blrs_pkg::CFG_LUX_THRESHOLD: cfg_q.lux_threshold    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Handshake: step fires when the result register is free or draining
	assign advance   = in_valid_s1 && (!out_valid_q || res.ready);
	assign evt.ready = !in_valid_s1 || advance;

	// Event register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (evt.ready) begin
			in_valid_s1 <= evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			kind_s1 <= evt.kind;
			lux_s1  <= evt.lux;
			disp_s1 <= evt.display_brightness;
		end
	end

	blrs_step #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.IDX_W        (IDX_W)
	) u_step (
		.cfg               (cfg_q),
		.st                (st_q),
		.ramp_index        (ramp_index_q),
		.kind              (kind_s1),
		.lux               (lux_s1),
		.display_brightness(disp_s1),
		.st_nxt            (st_nxt),
		.ramp_index_nxt    (ramp_index_nxt),
		.res               (res_nxt)
	);

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase       <= blrs_pkg::PH_INIT;
			st_q.timer_left  <= 16'd0;
			st_q.timer_armed <= 1'b0;
			st_q.stored_lux  <= 24'd0;
			ramp_index_q     <= '0;
		end else if (advance) begin
			st_q         <= st_nxt;
			ramp_index_q <= ramp_index_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign res.valid           = out_valid_q;
	assign res.phase           = res_q.phase;
	assign res.set_brightness  = res_q.set_brightness;
	assign res.brightness      = res_q.brightness;
	assign res.restore_request = res_q.restore_request;

	// Checks
	a_restore_ends: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.restore_request |-> res.phase == blrs_pkg::PHASE_END)
		else $error("restore request outside the ended phase");

	a_timer_phase: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.timer_armed |-> (st_q.phase != blrs_pkg::PH_INIT && st_q.phase != blrs_pkg::PH_END))
		else $error("timer running in init or ended phase");

	a_index_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ramp_index_q <= IDX_W'(TABLE_ENTRIES))
		else $error("ramp index past the table");

	a_limit: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.set_brightness |-> res.brightness <= cfg_q.ramp_limit)
		else $error("brightness above ramp limit");

endmodule
